// ===== rtl/core/gdc_pkg.sv =====
// Shared types, constants and calendar functions for the Gregorian date checker.
package gdc_pkg;

  localparam int unsigned YearW  = 16;
  localparam int unsigned DayW   = 8;
  localparam int unsigned MonthW = 8;
  localparam int unsigned CountW = 25;
  localparam int unsigned GapW   = 26;
  localparam int unsigned LeapW  = 14;

  localparam logic [YearW-1:0] BASE_YEAR_RST = 16'd2000;

  // Reciprocal of 100 scaled by 2^23; exact for every 16-bit dividend.
  localparam logic [16:0] DIV100_MUL   = 17'd83887;
  localparam int unsigned DIV100_SHIFT = 23;

  localparam logic signed [1:0] ORD_FIRST_LATER   = 2'sb11;
  localparam logic signed [1:0] ORD_EQUAL         = 2'sb00;
  localparam logic signed [1:0] ORD_FIRST_EARLIER = 2'sb01;

  typedef enum logic [1:0] {
    STAT_VALID     = 2'd0,
    STAT_BAD_DAY   = 2'd1,
    STAT_BAD_MONTH = 2'd2
  } status_e;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_t;

  typedef struct packed {
    status_e           status;
    logic [CountW-1:0] count;
  } date_res_t;

  function automatic logic [9:0] div100(logic [YearW-1:0] v);
    logic [32:0] prod;
    prod = 33'(v) * 33'(DIV100_MUL);
    return prod[DIV100_SHIFT +: 10];
  endfunction

  function automatic logic is_leap(logic [YearW-1:0] y);
    logic [9:0]  q100;
    logic [16:0] r100;
    q100 = div100(y);
    r100 = 17'(y) - 17'(q100) * 17'd100;
    return (y[1:0] == 2'b00) && ((r100 != 17'd0) || (q100[1:0] == 2'b00));
  endfunction

  // Number of leap years in the years 0 to n-1.
  function automatic logic [LeapW-1:0] leaps_before(logic [YearW-1:0] n);
    logic [YearW-1:0] k;
    logic [9:0]       q100;
    k    = n - 16'd1;
    q100 = div100(k);
    if (n == '0) begin
      return '0;
    end
    return LeapW'(k[YearW-1:2]) - LeapW'(q100) + LeapW'(q100[9:2]) + LeapW'(1);
  endfunction

  // Days before the given month in a common year; index 13 is the whole year.
  function automatic logic [8:0] month_start(logic [3:0] m);
    case (m)
      4'd2:    return 9'd31;
      4'd3:    return 9'd59;
      4'd4:    return 9'd90;
      4'd5:    return 9'd120;
      4'd6:    return 9'd151;
      4'd7:    return 9'd181;
      4'd8:    return 9'd212;
      4'd9:    return 9'd243;
      4'd10:   return 9'd273;
      4'd11:   return 9'd304;
      4'd12:   return 9'd334;
      4'd13:   return 9'd365;
      default: return 9'd0;
    endcase
  endfunction

  function automatic logic [4:0] month_len(logic [MonthW-1:0] m, logic leap);
    case (m)
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: return 5'd31;
      8'd4, 8'd6, 8'd9, 8'd11:                    return 5'd30;
      8'd2:    return leap ? 5'd29 : 5'd28;
      default: return 5'd0;
    endcase
  endfunction

endpackage

// ===== rtl/core/gdc_if.sv =====
// Request and response channel interfaces of the Gregorian date checker.
interface gdc_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  day_a;
  logic [7:0]  month_a;
  logic [15:0] year_a;
  logic [7:0]  day_b;
  logic [7:0]  month_b;
  logic [15:0] year_b;

  modport source (output valid, day_a, month_a, year_a, day_b, month_b, year_b,
                  input ready);
  modport sink (input valid, day_a, month_a, year_a, day_b, month_b, year_b,
                output ready);
endinterface

interface gdc_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status_a;
  logic [1:0]         status_b;
  logic signed [1:0]  order;
  logic signed [25:0] day_gap;

  modport source (output valid, status_a, status_b, order, day_gap, input ready);
  modport sink (input valid, status_a, status_b, order, day_gap, output ready);
endinterface

// ===== rtl/core/gregorian_date_check_and_difference_core.sv =====
// Top level: checks two dates, orders them and gives their day-count difference.
// A request is held in the input register and its response in the result register.
// Throughput: one request per cycle while the response is taken, set by the register pair.
// The calendar arithmetic sits in a single combinational stage between those two registers.
// Reset clears both valid flags and sets the base year to 2000.
module gregorian_date_check_and_difference_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  gdc_req_if.sink     req_i,
  gdc_rsp_if.source   rsp_o
);
  import gdc_pkg::*;

  logic [YearW-1:0] base_year_q;
  logic [LeapW-1:0] base_leaps;

  logic      in_valid_q;
  date_t     date_a_q, date_b_q;
  logic      advance;

  date_res_t res_a, res_b;
  logic signed [1:0] ord;
  logic [GapW-1:0]   gap;

  logic               out_valid_q;
  logic [1:0]         status_a_q, status_b_q;
  logic signed [1:0]  order_q;
  logic [GapW-1:0]    gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_year_q <= BASE_YEAR_RST;
    end else if (cfg_we_i) begin
      base_year_q <= cfg_wdata_i;
    end
  end

  assign base_leaps = leaps_before(base_year_q);

  assign advance     = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      date_a_q <= '{day: req_i.day_a, month: req_i.month_a, year: req_i.year_a};
      date_b_q <= '{day: req_i.day_b, month: req_i.month_b, year: req_i.year_b};
    end
  end

  gdc_date_unit u_date_a (
    .date_i       (date_a_q),
    .base_year_i  (base_year_q),
    .base_leaps_i (base_leaps),
    .res_o        (res_a)
  );

  gdc_date_unit u_date_b (
    .date_i       (date_b_q),
    .base_year_i  (base_year_q),
    .base_leaps_i (base_leaps),
    .res_o        (res_b)
  );

  always_comb begin
    if (date_a_q.year > date_b_q.year) begin
      ord = ORD_FIRST_LATER;
    end else if (date_a_q.year < date_b_q.year) begin
      ord = ORD_FIRST_EARLIER;
    end else if (date_a_q.month > date_b_q.month) begin
      ord = ORD_FIRST_LATER;
    end else if (date_a_q.month < date_b_q.month) begin
      ord = ORD_FIRST_EARLIER;
    end else if (date_a_q.day > date_b_q.day) begin
      ord = ORD_FIRST_LATER;
    end else if (date_a_q.day < date_b_q.day) begin
      ord = ORD_FIRST_EARLIER;
    end else begin
      ord = ORD_EQUAL;
    end
  end

  assign gap = (ord == ORD_FIRST_EARLIER) ? (GapW'(res_b.count) - GapW'(res_a.count))
                                          : (GapW'(res_a.count) - GapW'(res_b.count));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      status_a_q <= res_a.status;
      status_b_q <= res_b.status;
      order_q    <= ord;
      gap_q      <= gap;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.status_a = status_a_q;
  assign rsp_o.status_b = status_b_q;
  assign rsp_o.order    = order_q;
  assign rsp_o.day_gap  = gap_q;

endmodule

// ===== rtl/core/gdc_date_unit.sv =====
// Validity check and day count of one date relative to the base year.
module gdc_date_unit (
  input  gdc_pkg::date_t                   date_i,
  input  logic [gdc_pkg::YearW-1:0]        base_year_i,
  input  logic [gdc_pkg::LeapW-1:0]        base_leaps_i,
  output gdc_pkg::date_res_t               res_o
);
  import gdc_pkg::*;

  logic              leap;
  logic              after_base;
  logic [YearW-1:0]  year_diff;
  logic [CountW-1:0] year_days;
  logic [3:0]        month_idx;
  logic [CountW-1:0] month_days;
  logic [4:0]        len;
  status_e           status;

  assign leap       = is_leap(date_i.year);
  assign after_base = date_i.year > base_year_i;
  assign year_diff  = date_i.year - base_year_i;

  always_comb begin
    if (after_base) begin
      year_days = CountW'(25'(year_diff) * 25'd365) + CountW'(leaps_before(date_i.year))
                  - CountW'(base_leaps_i);
    end else begin
      year_days = '0;
    end
  end

  assign month_idx = (date_i.month > 8'd13) ? 4'd13 : date_i.month[3:0];

  always_comb begin
    month_days = CountW'(month_start(month_idx));
    if ((month_idx > 4'd2) && leap) begin
      month_days = month_days + CountW'(1);
    end
  end

  assign len       = month_len(date_i.month, leap);
  assign res_o.count = year_days + month_days + CountW'(date_i.day);

  always_comb begin
    if (!after_base) begin
      status = STAT_BAD_DAY;
    end else if ((date_i.month < 8'd1) || (date_i.month > 8'd12)) begin
      status = STAT_BAD_MONTH;
    end else if ((date_i.day >= 8'd1) && (date_i.day <= 8'(len))) begin
      status = STAT_VALID;
    end else begin
      status = STAT_BAD_DAY;
    end
  end

  assign res_o.status = status;

endmodule
